[rtl/qai_pkg.sv]
// Types, widths and constants for the quaternion attitude integrator.
// Every other file of the block but qai_out_if and qai_checker imports this package.
`default_nettype none
package qai_pkg;
    localparam int QUAT_W = 32;              // Q2.30 attitude components
    localparam int QF     = QUAT_W - 2;
    localparam int RATE_W = 32;              // Q8.24 rad/s
    localparam int DT_W   = 24;              // Q0.24 s
    localparam int A_W    = RATE_W + DT_W;   // rate * dt, 48 fraction bits
    localparam int P_W    = 42;              // updated component before normalising
    localparam int B_W    = P_W;             // multiplier operand width
    localparam int PROD_W = A_W + B_W;
    localparam int ACC_W  = 92;
    localparam int SQ_W   = 2 * P_W;
    localparam int LEN_W  = P_W;
    localparam int DIVN_W = P_W + QF;

    localparam logic signed [QUAT_W-1:0] Q_ONE = QUAT_W'(1) << QF;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_MWAIT, ST_SQRT, ST_SWAIT, ST_DIV, ST_DWAIT, ST_OUT
    } t_state;

    typedef enum logic [1:0] {PH_RATE, PH_SUM, PH_SQ, PH_GRAV} t_phase;

    typedef enum logic {OP_INTEGRATE = 1'b0, OP_LOAD = 1'b1} t_op;

    // one product term: first operand index, second operand index, subtract, clears sum
    typedef struct packed {
        logic [1:0] qsel;
        logic [1:0] asel;
        logic       neg;
        logic       first;
    } t_term;

    // increment terms: components w,x,y,z = 0..3, angles x,y,z = 0..2
    function automatic t_term f_sum_term(input logic [1:0] comp, input logic [1:0] k);
        t_term t;
        t = '{qsel: 2'd0, asel: 2'd0, neg: 1'b0, first: (k == 2'd0)};
        case ({comp, k})
            4'b00_00: begin t.qsel = 2'd1; t.asel = 2'd0; t.neg = 1'b1; end
            4'b00_01: begin t.qsel = 2'd2; t.asel = 2'd1; t.neg = 1'b1; end
            4'b00_10: begin t.qsel = 2'd3; t.asel = 2'd2; t.neg = 1'b1; end
            4'b01_00: begin t.qsel = 2'd0; t.asel = 2'd0; end
            4'b01_01: begin t.qsel = 2'd2; t.asel = 2'd2; end
            4'b01_10: begin t.qsel = 2'd3; t.asel = 2'd1; t.neg = 1'b1; end
            4'b10_00: begin t.qsel = 2'd0; t.asel = 2'd1; end
            4'b10_01: begin t.qsel = 2'd1; t.asel = 2'd2; t.neg = 1'b1; end
            4'b10_10: begin t.qsel = 2'd3; t.asel = 2'd0; end
            4'b11_00: begin t.qsel = 2'd0; t.asel = 2'd2; end
            4'b11_01: begin t.qsel = 2'd1; t.asel = 2'd1; end
            4'b11_10: begin t.qsel = 2'd2; t.asel = 2'd0; t.neg = 1'b1; end
            default:  begin t.qsel = 2'd0; t.asel = 2'd0; end
        endcase
        return t;
    endfunction

    // gravity terms: xz - wy, wx + yz, xx + yy
    function automatic t_term f_grav_term(input logic [2:0] k);
        t_term t;
        t = '{qsel: 2'd0, asel: 2'd0, neg: 1'b0, first: ~k[0]};
        case (k)
            3'd0:    begin t.qsel = 2'd1; t.asel = 2'd3; end
            3'd1:    begin t.qsel = 2'd0; t.asel = 2'd2; t.neg = 1'b1; end
            3'd2:    begin t.qsel = 2'd0; t.asel = 2'd1; end
            3'd3:    begin t.qsel = 2'd2; t.asel = 2'd3; end
            3'd4:    begin t.qsel = 2'd1; t.asel = 2'd1; end
            3'd5:    begin t.qsel = 2'd2; t.asel = 2'd2; end
            default: begin t.qsel = 2'd0; t.asel = 2'd0; end
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

[rtl/qai_in_if.sv]
// Input channel of the attitude integrator: handshake and item fields.
// Depends on qai_pkg for field widths.
`default_nettype none
interface qai_in_if import qai_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic        [DT_W-1:0]   step_time;
    logic signed [31:0]       load_w;
    logic signed [31:0]       load_x;
    logic signed [31:0]       load_y;
    logic signed [31:0]       load_z;

    modport source (output valid, op, rate_x, rate_y, rate_z, step_time,
                    load_w, load_x, load_y, load_z, input ready);
    modport sink   (input valid, op, rate_x, rate_y, rate_z, step_time,
                    load_w, load_x, load_y, load_z, output ready);
endinterface
`default_nettype wire

[rtl/qai_out_if.sv]
// Result channel of the attitude integrator: gravity vector and attitude.
// No package dependency.
`default_nettype none
interface qai_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic signed [31:0] gravity_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source (output valid, gravity_x, gravity_y, gravity_z,
                    quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, gravity_x, gravity_y, gravity_z,
                    quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

[rtl/qai_mul.sv]
// Bit-serial signed multiplier, one multiplier bit per cycle (shift-add).
// Depends on qai_pkg.
`default_nettype none
module qai_mul import qai_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [A_W-1:0]    i_a,
    input  wire logic signed [B_W-1:0]    i_b,
    output logic                          o_done,
    output logic signed [PROD_W-1:0]      o_prod
);
    localparam int CW = $clog2(B_W);
    localparam logic [CW-1:0] LAST = CW'(B_W - 1);

    logic [A_W-1:0]    r_ma, n_ma;
    logic [PROD_W:0]   r_p, n_p;        // {partial sum, remaining multiplier bits}
    logic              r_neg, n_neg;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [A_W:0]      hi_sum;

    always_comb begin
        n_ma   = r_ma;
        n_p    = r_p;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        hi_sum = r_p[PROD_W:B_W] + (r_p[0] ? {1'b0, r_ma} : '0);
        if (i_start) begin
            n_ma   = i_a[A_W-1] ? A_W'(-i_a) : A_W'(i_a);
            n_p    = {(A_W + 1)'(0), (i_b[B_W-1] ? B_W'(-i_b) : B_W'(i_b))};
            n_neg  = i_a[A_W-1] ^ i_b[B_W-1];
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_p   = {1'b0, hi_sum, r_p[B_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma  <= n_ma;
        r_p   <= n_p;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_p[PROD_W-1:0]) : $signed(r_p[PROD_W-1:0]);
endmodule
`default_nettype wire

[rtl/qai_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on qai_pkg.
`default_nettype none
module qai_sqrt import qai_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SQ_W-1:0]   i_rad,
    output logic                   o_done,
    output logic [LEN_W-1:0]       o_root
);
    localparam int RW = LEN_W + 4;
    localparam int CW = $clog2(LEN_W);
    localparam logic [CW-1:0] LAST = CW'(LEN_W - 1);

    logic [SQ_W-1:0]  r_rad, n_rad;
    logic [RW-1:0]    r_rem, n_rem;
    logic [LEN_W-1:0] r_root, n_root;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [RW-1:0]    t_val;
    logic [RW-1:0]    trial;

    always_comb begin
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        t_val  = {r_rem[RW-3:0], r_rad[SQ_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        if (i_start) begin
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[SQ_W-3:0], 2'b00};
            if (t_val >= trial) begin
                n_rem  = t_val - trial;
                n_root = {r_root[LEN_W-2:0], 1'b1};
            end else begin
                n_rem  = t_val;
                n_root = {r_root[LEN_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

[rtl/qai_div.sv]
// Restoring divider, one quotient bit per cycle: round(p * 2^QF / len),
// ties away from zero, saturated to the attitude width. Depends on qai_pkg.
`default_nettype none
module qai_div import qai_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [P_W-1:0]    i_p,
    input  wire logic [LEN_W-1:0]         i_len,
    output logic                          o_done,
    output logic signed [QUAT_W-1:0]      o_quot
);
    localparam int CW = $clog2(DIVN_W);
    localparam logic [CW-1:0] LAST = CW'(DIVN_W - 1);
    localparam logic [DIVN_W:0] MAXPOS = (DIVN_W + 1)'(1) << (QUAT_W - 1);

    logic [DIVN_W-1:0] r_num, n_num;
    logic [DIVN_W-1:0] r_q, n_q;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_neg, n_neg;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [LEN_W:0]    t_val;
    logic              rnd;
    logic [DIVN_W:0]   mag;

    always_comb begin
        n_num  = r_num;
        n_q    = r_q;
        n_rem  = r_rem;
        n_len  = r_len;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        t_val  = {r_rem, r_num[DIVN_W-1]};
        if (i_start) begin
            n_num  = {(i_p[P_W-1] ? P_W'(-i_p) : P_W'(i_p)), QF'(0)};
            n_q    = '0;
            n_rem  = '0;
            n_len  = i_len;
            n_neg  = i_p[P_W-1];
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[DIVN_W-2:0], 1'b0};
            if (t_val >= {1'b0, r_len}) begin
                n_rem = LEN_W'(t_val - {1'b0, r_len});
                n_q   = {r_q[DIVN_W-2:0], 1'b1};
            end else begin
                n_rem = t_val[LEN_W-1:0];
                n_q   = {r_q[DIVN_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_comb begin
        rnd = {r_rem, 1'b0} >= {1'b0, r_len};
        mag = {1'b0, r_q} + (DIVN_W + 1)'(rnd);
        if (!r_neg) begin
            o_quot = (mag >= MAXPOS) ? {1'b0, {(QUAT_W-1){1'b1}}} : QUAT_W'(mag);
        end else begin
            o_quot = (mag > MAXPOS) ? {1'b1, {(QUAT_W-1){1'b0}}} : -QUAT_W'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_len <= n_len;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

[rtl/quaternion_attitude_integrator_unit.sv]
// Top level of the quaternion attitude integrator: sequencer, attitude store and
// result register. Depends on qai_pkg, qai_in_if, qai_out_if, qai_mul, qai_sqrt, qai_div.
//
// Keeps an attitude quaternion in Q2.30 (identity after reset). An integrate item
// applies a first-order update from the gyro rate and step time, then renormalises
// it (identity if its length is zero); a load item sets the quaternion as given.
// Each item yields one result: the body-frame gravity vector and the new attitude.
// One item is worked on at a time. All products go through one bit-serial
// multiplier of 42 shift-add steps each, so its 25 products dominate an
// integrate item, which also takes a square root and, unless the length is
// zero, four divides; a load item needs only the six gravity products. A
// finished result waits in the output register while the next item is
// accepted.
`default_nettype none
module quaternion_attitude_integrator_unit import qai_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qai_in_if.sink     i_in,
    qai_out_if.source  o_out
);
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [3:0] r_k, n_k;
    logic [1:0] r_i, n_i;

    logic signed [QUAT_W-1:0] r_q [4];
    logic signed [QUAT_W-1:0] n_q [4];
    logic signed [RATE_W-1:0] r_rate [3];
    logic        [DT_W-1:0]   r_dt;
    logic signed [A_W-1:0]    r_a [3];
    logic signed [A_W-1:0]    n_a [3];
    logic signed [P_W-1:0]    r_p [4];
    logic signed [P_W-1:0]    n_p [4];
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [SQ_W-1:0]          r_sq, n_sq;
    logic [LEN_W-1:0]         r_len, n_len;
    logic signed [31:0]       r_g [3];
    logic signed [31:0]       n_g [3];

    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_o [7];
    logic signed [31:0] n_o [7];

    logic                     mul_start, mul_done;
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     sqrt_start, sqrt_done;
    logic [LEN_W-1:0]         sqrt_root;
    logic                     div_start, div_done;
    logic signed [QUAT_W-1:0] div_quot;

    t_term                    term;
    logic signed [ACC_W-1:0]  prod_acc;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  rnd_acc;
    logic                     in_acc;

    // drop 29 fraction bits (round half up already added) and saturate to 32
    function automatic logic signed [31:0] f_sat32(input logic signed [ACC_W-1:0] e);
        logic signed [ACC_W-30:0] s;
        s = e[ACC_W-1:29];
        if (s > (ACC_W - 29)'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (s < (ACC_W - 29)'(32'sh8000_0000))
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    qai_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_prod(mul_prod)
    );

    qai_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
        .i_rad(r_sq), .o_done(sqrt_done), .o_root(sqrt_root)
    );

    qai_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_p(r_p[r_i]), .i_len(r_len), .o_done(div_done), .o_quot(div_quot)
    );

    assign in_acc = i_in.valid && i_in.ready;

    // operand selection for the shared multiplier
    always_comb begin
        term  = (r_phase == PH_SUM) ? f_sum_term(r_i, r_k[1:0]) : f_grav_term(r_k[2:0]);
        mul_a = '0;
        mul_b = '0;
        case (r_phase)
            PH_RATE: begin
                mul_a = A_W'(r_rate[r_k[1:0]]);
                mul_b = B_W'($signed({1'b0, r_dt}));
            end
            PH_SUM: begin
                mul_a = r_a[term.asel];
                mul_b = B_W'(r_q[term.qsel]);
            end
            PH_SQ: begin
                mul_a = A_W'(r_p[r_i]);
                mul_b = r_p[r_i];
            end
            PH_GRAV: begin
                mul_a = A_W'(r_q[term.qsel]);
                mul_b = B_W'(r_q[term.asel]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_acc = ACC_W'(mul_prod);
        acc_sum  = (term.first ? '0 : r_acc) + (term.neg ? -prod_acc : prod_acc);
        rnd_acc  = acc_sum + (ACC_W'(1) <<< 48);
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_k        = r_k;
        n_i        = r_i;
        n_q        = r_q;
        n_a        = r_a;
        n_p        = r_p;
        n_acc      = r_acc;
        n_sq       = r_sq;
        n_len      = r_len;
        n_g        = r_g;
        n_o        = r_o;
        n_ovalid   = r_ovalid;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        i_in.ready = (r_state == ST_IDLE);

        if (o_out.ready)
            n_ovalid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_k     = '0;
                    n_i     = '0;
                    n_state = ST_MUL;
                    if (i_in.op == OP_LOAD) begin
                        n_q[0]  = i_in.load_w;
                        n_q[1]  = i_in.load_x;
                        n_q[2]  = i_in.load_y;
                        n_q[3]  = i_in.load_z;
                        n_phase = PH_GRAV;
                    end else begin
                        n_phase = PH_RATE;
                    end
                end
            end
            ST_MUL: begin
                mul_start = 1'b1;
                n_state   = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (mul_done) begin
                    n_state = ST_MUL;
                    n_acc   = acc_sum;
                    n_k     = r_k + 1'b1;
                    case (r_phase)
                        PH_RATE: begin
                            n_a[r_k[1:0]] = mul_prod[A_W-1:0];
                            if (r_k == 4'd2) begin
                                n_k     = '0;
                                n_phase = PH_SUM;
                            end
                        end
                        PH_SUM: begin
                            if (r_k == 4'd2) begin
                                // half the sum, rounded to the attitude fraction
                                n_p[r_i] = P_W'(rnd_acc[ACC_W-1:49] +
                                                (ACC_W - 49)'(r_q[r_i]));
                                n_k = '0;
                                n_i = r_i + 1'b1;
                                if (r_i == 2'd3) begin
                                    n_phase = PH_SQ;
                                    n_sq    = '0;
                                end
                            end
                        end
                        PH_SQ: begin
                            n_sq = r_sq + mul_prod[SQ_W-1:0];
                            n_i  = r_i + 1'b1;
                            if (r_i == 2'd3)
                                n_state = ST_SQRT;
                        end
                        PH_GRAV: begin
                            case (r_k)
                                4'd1: n_g[0] = f_sat32(acc_sum + (ACC_W'(1) <<< 28));
                                4'd3: n_g[1] = f_sat32(acc_sum + (ACC_W'(1) <<< 28));
                                4'd5: n_g[2] = f_sat32((ACC_W'(1) <<< 59) - acc_sum +
                                                       (ACC_W'(1) <<< 28));
                                default: ;
                            endcase
                            if (r_k == 4'd5)
                                n_state = ST_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SQRT: begin
                sqrt_start = 1'b1;
                n_state    = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (sqrt_done) begin
                    n_len = sqrt_root;
                    n_i   = '0;
                    if (sqrt_root == '0) begin
                        n_q[0]  = Q_ONE;
                        n_q[1]  = '0;
                        n_q[2]  = '0;
                        n_q[3]  = '0;
                        n_k     = '0;
                        n_phase = PH_GRAV;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                div_start = 1'b1;
                n_state   = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    n_q[r_i] = div_quot;
                    n_i      = r_i + 1'b1;
                    if (r_i == 2'd3) begin
                        n_k     = '0;
                        n_phase = PH_GRAV;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_OUT: begin
                // previous item still held: wait for it to go
                if (!r_ovalid || o_out.ready) begin
                    n_o[0]   = r_g[0];
                    n_o[1]   = r_g[1];
                    n_o[2]   = r_g[2];
                    n_o[3]   = r_q[0];
                    n_o[4]   = r_q[1];
                    n_o[5]   = r_q[2];
                    n_o[6]   = r_q[3];
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_RATE;
            r_k      <= '0;
            r_i      <= '0;
            r_ovalid <= 1'b0;
            r_q[0]   <= Q_ONE;
            r_q[1]   <= '0;
            r_q[2]   <= '0;
            r_q[3]   <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_k      <= n_k;
            r_i      <= n_i;
            r_ovalid <= n_ovalid;
            r_q      <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rate[0] <= i_in.rate_x;
            r_rate[1] <= i_in.rate_y;
            r_rate[2] <= i_in.rate_z;
            r_dt      <= i_in.step_time;
        end
        r_a   <= n_a;
        r_p   <= n_p;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_len <= n_len;
        r_g   <= n_g;
        r_o   <= n_o;
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.gravity_x = r_o[0];
    assign o_out.gravity_y = r_o[1];
    assign o_out.gravity_z = r_o[2];
    assign o_out.quat_w    = r_o[3];
    assign o_out.quat_x    = r_o[4];
    assign o_out.quat_y    = r_o[5];
    assign o_out.quat_z    = r_o[6];
endmodule
`default_nettype wire

[rtl/qai_checker.sv]
// Port-level checks for the attitude integrator, bound to the top level.
// No package dependency.
`default_nettype none
module qai_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_quat_w
);
    // a held result stays valid and its quat_w stays put until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_quat_w))
        else $error("result dropped or changed while stalled");

    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    // one item at a time: no second item straight after an accepted one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while busy");

    // no result can appear the cycle after an item enters an empty block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared too early");
endmodule

bind quaternion_attitude_integrator_unit qai_checker u_qai_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_quat_w(o_out.quat_w)
);
`default_nettype wire
